>>> rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Types and constants shared by the 3x3 matrix inverse unit.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned NLANE  = 9;
  localparam int unsigned AW     = 64;
  localparam int unsigned DW     = 97;
  localparam int unsigned RW     = 98;
  localparam int unsigned QBITS  = 33;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;
  localparam int unsigned THRW   = 63;

  localparam logic [THRW-1:0] THR_RESET = 63'd281475;

  // cofactor k = m[a]*m[b] - m[c]*m[d]
  localparam int unsigned ADJ_IDX [NLANE][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } mi3_in_t;

  typedef struct packed {
    logic signed [31:0] r00;
    logic signed [31:0] r01;
    logic signed [31:0] r02;
    logic signed [31:0] r10;
    logic signed [31:0] r11;
    logic signed [31:0] r12;
    logic signed [31:0] r20;
    logic signed [31:0] r21;
    logic signed [31:0] r22;
    logic               singular;
  } mi3_out_t;

  typedef struct packed {
    logic [NLANE-1:0][AW-1:0] amag;
    logic [NLANE-1:0]         aneg;
    logic                     dneg;
    logic [DW-1:0]            dmag;
    logic                     singular;
  } mi3_job_t;

endpackage

>>> rtl/mi3_queue.sv
// ----------------------------------------------------------------------------
// mi3_queue
// Short register queue between the cofactor front end and the divider.
// ----------------------------------------------------------------------------
module mi3_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mi3_pkg::mi3_job_t wdata,
  output logic              full,
  input  logic              pop,
  output mi3_pkg::mi3_job_t rdata,
  output logic              empty
);
  import mi3_pkg::*;

  mi3_job_t       mem_r [QDEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QAW:0]   cnt_r;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty queue");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count lost a beat");

endmodule

>>> rtl/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front
// Cofactors, determinant and singular test; one matrix per cycle unless in_stall holds it.
// ----------------------------------------------------------------------------
module mi3_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  mi3_pkg::mi3_in_t         in_data,
  input  logic [mi3_pkg::THRW-1:0] thr,
  input  logic                     q_full,
  output logic                     q_push,
  output mi3_pkg::mi3_job_t        q_data
);
  import mi3_pkg::*;

  logic signed [31:0] m [NLANE];
  logic               adv;
  logic [8:1]         vld_r;
  logic signed [63:0] pa_r [NLANE];
  logic signed [63:0] pb_r [NLANE];
  logic signed [31:0] row1_r [3];
  logic signed [31:0] row2_r [3];
  logic signed [64:0] adj_r [NLANE];
  logic [63:0]        pl_r [3];
  logic [63:0]        ph_r [3];
  logic [2:0]         tneg3_r;
  logic [95:0]        t_r [3];
  logic [2:0]         tneg4_r;
  logic signed [96:0] term_r [3];
  logic signed [96:0] det_r;
  mi3_job_t           job_r [3:8];
  logic [AW-1:0]      amag_nxt [NLANE];
  logic [31:0]        mm_nxt [3];
  mi3_job_t           job3_nxt;
  mi3_job_t           job7_nxt;
  mi3_job_t           job8_nxt;

  assign m[0] = in_data.m00;
  assign m[1] = in_data.m01;
  assign m[2] = in_data.m02;
  assign m[3] = in_data.m10;
  assign m[4] = in_data.m11;
  assign m[5] = in_data.m12;
  assign m[6] = in_data.m20;
  assign m[7] = in_data.m21;
  assign m[8] = in_data.m22;

  assign adv      = !(vld_r[8] && q_full);
  assign in_stall = !adv;
  assign q_push   = vld_r[8] && !q_full;
  assign q_data   = job_r[8];

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      amag_nxt[k] = adj_r[k][64] ? 64'(-adj_r[k]) : adj_r[k][63:0];
    end
    for (int k = 0; k < 3; k++) begin
      mm_nxt[k] = row2_r[k][31] ? 32'(-row2_r[k]) : 32'(row2_r[k]);
    end
    job3_nxt = '0;
    for (int k = 0; k < NLANE; k++) begin
      job3_nxt.amag[k] = amag_nxt[k];
      job3_nxt.aneg[k] = adj_r[k][64];
    end
    job7_nxt      = job_r[6];
    job7_nxt.dneg = det_r[96];
    job7_nxt.dmag = det_r[96] ? DW'(-det_r) : DW'(det_r);
    job8_nxt          = job_r[7];
    job8_nxt.singular = (job_r[7].dmag == '0) ||
                        (job_r[7].dmag < {(DW-THRW)'(0), thr});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[7:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NLANE; k++) begin
        pa_r[k] <= m[ADJ_IDX[k][0]] * m[ADJ_IDX[k][1]];
        pb_r[k] <= m[ADJ_IDX[k][2]] * m[ADJ_IDX[k][3]];
        adj_r[k] <= {pa_r[k][63], pa_r[k]} - {pb_r[k][63], pb_r[k]};
      end
      for (int k = 0; k < 3; k++) begin
        row1_r[k]  <= m[k];
        row2_r[k]  <= row1_r[k];
        pl_r[k]    <= 64'(mm_nxt[k]) * 64'(amag_nxt[k*3][31:0]);
        ph_r[k]    <= 64'(mm_nxt[k]) * 64'(amag_nxt[k*3][63:32]);
        tneg3_r[k] <= row2_r[k][31] ^ adj_r[k*3][64];
        t_r[k]     <= {32'd0, pl_r[k]} + {ph_r[k], 32'd0};
        tneg4_r[k] <= tneg3_r[k];
        term_r[k]  <= tneg4_r[k] ? -$signed({1'b0, t_r[k]}) : $signed({1'b0, t_r[k]});
      end
      det_r <= term_r[0] + term_r[1] + term_r[2];

      job_r[3] <= job3_nxt;
      job_r[4] <= job_r[3];
      job_r[5] <= job_r[4];
      job_r[6] <= job_r[5];
      job_r[7] <= job7_nxt;
      job_r[8] <= job8_nxt;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("push while queue full");
  a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[8] && q_full |=> vld_r[8] && $stable(job_r[8]))
    else $error("front tail beat dropped under stall");
  a_zero_det: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[8] && job_r[8].dmag == '0 |-> job_r[8].singular)
    else $error("zero determinant not flagged");

endmodule

>>> rtl/mi3_back.sv
// ----------------------------------------------------------------------------
// mi3_back
// Nine-lane pipelined restoring divider, saturation and output register.
// ----------------------------------------------------------------------------
module mi3_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  output logic              q_pop,
  input  mi3_pkg::mi3_job_t q_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mi3_pkg::mi3_out_t out_data
);
  import mi3_pkg::*;

  localparam int          NW     = AW + 2 * FRAC_BITS;
  localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);

  logic                   adv;
  logic [QBITS:0]         vld_r;
  logic [DW-1:0]          dmag_r [QBITS+1];
  logic [QBITS:0]         sing_r;
  logic [NLANE-1:0]       neg_r  [QBITS+1];
  logic [NLANE-1:0]       ovf_r  [QBITS+1];
  logic [RW-1:0]          rem_r  [QBITS+1][NLANE];
  logic [QBITS-1:0]       quo_r  [QBITS+1][NLANE];
  logic [QBITS-1:0]       nlo_r  [QBITS+1][NLANE];
  logic [NW-1:0]          num    [NLANE];
  logic [31:0]            res    [NLANE];
  logic                   out_vld_r;
  mi3_out_t               out_r;

  assign adv       = !(out_vld_r && out_stall);
  assign q_pop     = adv && !q_empty;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      num[k] = NW'(q_data.amag[k]) << (2 * FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[QBITS-1:0], !q_empty};
      out_vld_r <= vld_r[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dmag_r[0] <= q_data.dmag;
      sing_r[0] <= q_data.singular;
      for (int k = 0; k < NLANE; k++) begin
        neg_r[0][k]  <= q_data.aneg[k] ^ q_data.dneg;
        ovf_r[0][k]  <= 128'(num[k] >> QBITS) >= 128'(q_data.dmag);
        rem_r[0][k]  <= RW'(num[k] >> QBITS);
        quo_r[0][k]  <= '0;
        nlo_r[0][k]  <= num[k][QBITS-1:0];
      end
    end
  end

  for (genvar s = 1; s <= QBITS; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        dmag_r[s] <= dmag_r[s-1];
        sing_r[s] <= sing_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
      end
    end
    for (genvar k = 0; k < NLANE; k++) begin : g_lane
      logic [RW-1:0] trial;
      logic          ge;
      assign trial = {rem_r[s-1][k][RW-2:0], nlo_r[s-1][k][QBITS-s]};
      assign ge    = trial >= {1'b0, dmag_r[s-1]};
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[s][k] <= ge ? trial - {1'b0, dmag_r[s-1]} : trial;
          quo_r[s][k] <= {quo_r[s-1][k][QBITS-2:0], ge};
          nlo_r[s][k] <= nlo_r[s-1][k];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      if (sing_r[QBITS]) begin
        res[k] = (k % 4 == 0) ? ONE_FX : 32'd0;
      end else if (!neg_r[QBITS][k]) begin
        if (ovf_r[QBITS][k] || quo_r[QBITS][k] > 33'h0_7FFF_FFFF) res[k] = 32'h7FFF_FFFF;
        else res[k] = quo_r[QBITS][k][31:0];
      end else begin
        if (ovf_r[QBITS][k] || quo_r[QBITS][k] > 33'h0_8000_0000) res[k] = 32'h8000_0000;
        else res[k] = 32'(33'd0 - quo_r[QBITS][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.r00      <= res[0];
      out_r.r01      <= res[1];
      out_r.r02      <= res[2];
      out_r.r10      <= res[3];
      out_r.r11      <= res[4];
      out_r.r12      <= res[5];
      out_r.r20      <= res[6];
      out_r.r21      <= res[7];
      out_r.r22      <= res[8];
      out_r.singular <= sing_r[QBITS];
    end
  end

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("pop from empty queue");
  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |->
      out_data.r00 == ONE_FX && out_data.r01 == '0 && out_data.r22 == ONE_FX)
    else $error("singular beat is not the identity");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed under stall");

endmodule

>>> rtl/matrix3_inverse_unit.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_unit
// 3x3 Q-format matrix inverse via adjugate over determinant, with a
// programmable singular threshold.
// ----------------------------------------------------------------------------
//  channel | handshake            | beat
//  in_     | in_valid / in_stall  | mi3_in_t, nine signed entries
//  out_    | out_valid / out_stall| mi3_out_t, nine entries and singular
//  cfg_    | cfg_valid / cfg_ready| 63-bit singular threshold
//
//  One matrix per cycle while out_stall stays low. The path from input runs
//  through eight front stages, the queue, the divider entry stage, 33 quotient
//  stages and the output register.
//  Reset (rst_n low, synchronous) empties both pipelines and the queue and
//  loads the threshold with its default. Output stall holds the divider and
//  fills the four-beat queue before in_stall rises.
// ----------------------------------------------------------------------------
module matrix3_inverse_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  mi3_pkg::mi3_in_t         in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output mi3_pkg::mi3_out_t        out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [mi3_pkg::THRW-1:0] cfg_data
);
  import mi3_pkg::*;

  logic [THRW-1:0] thr_r;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  mi3_job_t        q_wdata;
  mi3_job_t        q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  mi3_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .thr      (thr_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  mi3_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  mi3_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives 3x3 Q16.16 matrices into the inverse unit and compares each result
// with an exact adjugate-over-determinant calculation, across several
// singular-threshold settings and random handshake gaps.
// ----------------------------------------------------------------------------
module testbench;
  import mi3_pkg::*;

  localparam int FB = 16;
  localparam int MAX_IDLE = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mi3_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mi3_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [THRW-1:0] cfg_data = '0;

  logic [THRW-1:0] threshold = THR_RESET;
  mi3_out_t inverse_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int singular_seen = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  matrix3_inverse_unit #(.FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic signed [31:0] entry_quotient(logic signed [127:0] adj,
                                                        logic signed [127:0] det);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    logic neg;
    num = (adj < 0) ? -adj : adj;
    den = (det < 0) ? -det : det;
    num = num << (2 * FB);
    q = num / den;
    neg = (adj < 0) != (det < 0);
    if (!neg) return (q > 128'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
    return (q > 128'h80000000) ? 32'h80000000 : 32'(-q);
  endfunction

  function automatic mi3_out_t invert_matrix(mi3_in_t mx);
    logic signed [127:0] m[9];
    logic signed [127:0] adj[9];
    logic signed [127:0] det;
    logic [127:0] dmag;
    logic signed [31:0] r[9];
    mi3_out_t res;
    m = '{mx.m00, mx.m01, mx.m02, mx.m10, mx.m11, mx.m12, mx.m20, mx.m21, mx.m22};
    adj[0] = m[4]*m[8] - m[5]*m[7]; adj[1] = m[2]*m[7] - m[1]*m[8];
    adj[2] = m[1]*m[5] - m[2]*m[4]; adj[3] = m[5]*m[6] - m[3]*m[8];
    adj[4] = m[0]*m[8] - m[2]*m[6]; adj[5] = m[2]*m[3] - m[0]*m[5];
    adj[6] = m[3]*m[7] - m[4]*m[6]; adj[7] = m[1]*m[6] - m[0]*m[7];
    adj[8] = m[0]*m[4] - m[1]*m[3];
    det = m[0]*adj[0] + m[1]*adj[3] + m[2]*adj[6];
    dmag = (det < 0) ? -det : det;
    res = '0;
    if (dmag == 0 || dmag < {65'd0, threshold}) begin
      res.r00 = 32'sd1 <<< FB;
      res.r11 = 32'sd1 <<< FB;
      res.r22 = 32'sd1 <<< FB;
      res.singular = 1'b1;
      return res;
    end
    for (int k = 0; k < 9; k++) r[k] = entry_quotient(adj[k], det);
    res = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], 1'b0};
    return res;
  endfunction

  task automatic send_matrix(mi3_in_t mx);
    if (!quiet) begin
      while ($urandom_range(99) < 21) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= mx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    inverse_q.push_back(invert_matrix(mx));
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (inverse_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THRW-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    threshold = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_entry();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(8'hFF)) - 128;
      2: return ($urandom_range(1) ? 32'sh0001_0000 : -32'sh0001_0000);
      3: return $signed({{14{$urandom_range(1) == 1}}, 18'($urandom)});
      default: return $signed({{8{$urandom_range(1) == 1}}, 24'($urandom)});
    endcase
  endfunction

  function automatic mi3_in_t rand_matrix();
    mi3_in_t mx;
    mx = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
          rand_entry(), rand_entry(), rand_entry(), rand_entry()};
    if ($urandom_range(9) == 0) begin
      mx.m20 = mx.m00;
      mx.m21 = mx.m01;
      mx.m22 = mx.m02;
    end
    return mx;
  endfunction

  task automatic test_directed;
    mi3_in_t mx;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] MX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MN = 32'sh8000_0000;
    send_matrix({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
    send_matrix('0);
    send_matrix({ONE<<<1, 32'd0, 32'd0, 32'd0, ONE<<<2, 32'd0, 32'd0, 32'd0, -ONE});
    send_matrix({MX, 32'd0, 32'd0, 32'd0, MX, 32'd0, 32'd0, 32'd0, MX});
    send_matrix({MN, 32'd0, 32'd0, 32'd0, MN, 32'd0, 32'd0, 32'd0, MN});
    send_matrix({MN, MX, MN, MX, MN, MX, MN, MX, MX});
    send_matrix({32'sd1, 32'd0, 32'd0, 32'd0, 32'sd1, 32'd0, 32'd0, 32'd0, 32'sd1});
    send_matrix({32'sd256, 32'd0, 32'd0, 32'd0, 32'sd256, 32'd0, 32'd0, 32'd0, 32'sd256});
    send_matrix({32'sd300, 32'd0, 32'd0, 32'd0, 32'sd300, 32'd0, 32'd0, 32'd0, -32'sd300});
    send_matrix({ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE<<<1, ONE});
    send_matrix({-32'sd1, MX, 32'd0, 32'd0, 32'sd1, MN, MX, 32'd0, 32'sd1});
    mx = {ONE, ONE<<<1, ONE*3, ONE*4, ONE*5, ONE*6, ONE*7, ONE*8, ONE*10};
    send_matrix(mx);
    send_matrix('1);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_matrix(rand_matrix());
  endtask

  task automatic test_back_to_back(int count);
    quiet = 1'b1;
    for (int i = 0; i < count; i++) send_matrix(rand_matrix());
    quiet = 1'b0;
  endtask

  always @(negedge clk) begin
    out_stall <= (!quiet && $urandom_range(99) < 21);
  end

  always @(posedge clk) begin
    mi3_out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.singular) singular_seen++;
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_res = inverse_q.pop_front();
        if (out_data !== exp_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", exp_res, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > MAX_IDLE) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(100);
    write_threshold('0);
    test_directed();
    test_random(80);
    write_threshold({THRW{1'b1}});
    test_random(40);
    write_threshold(63'h0001_0000_0000_0000);
    test_random(80);
    write_threshold(THR_RESET);
    test_back_to_back(100);
    test_random(100);
    drain();
    $display("covered %0d matrices, %0d singular, over five threshold settings",
             results_seen, singular_seen);
    if (mismatches == 0 && inverse_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
